// ===== src/signed_int_to_decimal_ascii_macros.svh =====
// Assertion macros for the signed integer to decimal text converter.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// same-cycle implication
`define SIDC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sidc assertion failed");

// next-cycle implication
`define SIDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sidc assertion failed");

`endif

// ===== src/sidc_pkg.sv =====
// Shared types and constants for the decimal text converter.
// No dependencies.
`default_nettype none

package sidc_pkg;

    localparam int NUMBER_W = 64;
    localparam int CHAR_W   = 7;

    localparam logic [CHAR_W-1:0] CH_MINUS = 7'd45;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;

    typedef struct packed {
        logic load;      // capture number, clear digits
        logic dabble;    // one shift-add-3 step
        logic load_dig;  // preset counter to digit count
        logic dshift;    // drop leading digit
        logic sel_sign;  // present minus sign
    } cmd_t;

    typedef struct packed {
        logic cnt_one;
        logic top_zero;
        logic minus;
    } sts_t;

endpackage

`default_nettype wire

// ===== src/sidc_dp.sv =====
// Datapath: magnitude capture, shift-add-3 BCD conversion, digit emission.
// Depends on sidc_pkg.
`default_nettype none

module sidc_dp #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic                           clk,
    input  wire logic [sidc_pkg::NUMBER_W-1:0]  number,
    input  wire sidc_pkg::cmd_t                 cmd,
    output sidc_pkg::sts_t                      sts,
    output logic [sidc_pkg::CHAR_W-1:0]         text_char,
    output logic                                last_char
);
    import sidc_pkg::*;

    // digits in 2^(VALUE_BITS-1); 1233/4096 approximates log10(2)
    localparam int NDIG = (((VALUE_BITS - 1) * 1233) >> 12) + 1;
    localparam int BW   = 4 * NDIG;
    localparam int CW   = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [BW-1:0]         bcd_reg, bcd_next;
    logic                  minus_reg, minus_next;
    logic [CW-1:0]         cnt_reg, cnt_next;

    logic [VALUE_BITS-1:0] raw;
    logic [BW-1:0]         adj;
    logic [3:0]            top;

    assign raw = number[VALUE_BITS-1:0];
    assign top = bcd_reg[BW-1 -: 4];

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                        : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        minus_next = minus_reg;
        cnt_next   = cnt_reg;
        if (cmd.load)
        begin
            minus_next = raw[VALUE_BITS-1];
            mag_next   = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
            bcd_next   = '0;
        end
        else if (cmd.dabble)
        begin
            bcd_next = {adj[BW-2:0], mag_reg[VALUE_BITS-1]};
            mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
        end
        else if (cmd.dshift)
        begin
            bcd_next = {bcd_reg[BW-5:0], 4'd0};
        end

        if (cmd.load)
            cnt_next = CW'(VALUE_BITS);
        else if (cmd.load_dig)
            cnt_next = CW'(NDIG);
        else if (cmd.dabble || cmd.dshift)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        bcd_reg   <= bcd_next;
        minus_reg <= minus_next;
        cnt_reg   <= cnt_next;
    end

    assign sts.cnt_one  = (cnt_reg == CW'(1));
    assign sts.top_zero = (top == 4'd0);
    assign sts.minus    = minus_reg;

    assign text_char = cmd.sel_sign ? CH_MINUS : CH_ZERO + {3'd0, top};
    assign last_char = !cmd.sel_sign && sts.cnt_one;

endmodule

`default_nettype wire

// ===== src/sidc_ctrl.sv =====
// Controller: sequences capture, conversion, leading-zero skip and emission.
// Depends on sidc_pkg.
`default_nettype none

module sidc_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire sidc_pkg::sts_t  sts,
    output sidc_pkg::cmd_t       cmd
);
    import sidc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.dabble = 1'b1;
                if (sts.cnt_one)
                begin
                    cmd.load_dig = 1'b1;
                    state_next   = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (sts.top_zero && !sts.cnt_one)
                    cmd.dshift = 1'b1;
                else
                    state_next = sts.minus ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN:
            begin
                cmd.sel_sign = 1'b1;
                if (out_ready)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    if (sts.cnt_one)
                        state_next = ST_IDLE;
                    else
                        cmd.dshift = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        in_ready_next  = (state_next == ST_IDLE);
        out_valid_next = (state_next == ST_SIGN) || (state_next == ST_EMIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== src/signed_int_to_decimal_ascii.sv =====
// Converts one signed integer per transaction into its decimal ASCII text, most
// significant character first, with a leading minus for negative values and
// last_char set on the final character. Only the low VALUE_BITS bits of number
// are used. An item is captured, converted by VALUE_BITS steps of the
// one-bit-per-cycle shift-add-3 loop, has each leading zero digit skipped,
// has its sign decided, and then emits its characters while out_ready is
// high; emission holds while out_ready is low. Skipped and emitted digits
// always total 19 for a 64-bit value. One item is processed at a time;
// in_ready rises again after the last character.
// Depends on sidc_pkg, sidc_ctrl, sidc_dp and the assertion macro header.
`default_nettype none
`include "signed_int_to_decimal_ascii_macros.svh"

module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [sidc_pkg::NUMBER_W-1:0]  number,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [sidc_pkg::CHAR_W-1:0]         text_char,
    output logic                                last_char
);
    import sidc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sidc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sidc_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk       (clk),
        .number    (number),
        .cmd       (cmd),
        .sts       (sts),
        .text_char (text_char),
        .last_char (last_char)
    );

    `SIDC_ASSERT_NOW(a_no_out_while_ready, in_ready, !out_valid)
    `SIDC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `SIDC_ASSERT_NEXT(a_idle_after_last, out_valid && out_ready && last_char, in_ready)
    `SIDC_ASSERT_NOW(a_sign_not_last, out_valid && text_char == CH_MINUS, !last_char)

endmodule

`default_nettype wire

// ===== sim/sidc_text_checker.sv =====
// Checker for the signed integer to decimal text converter.
// Watches both channels and predicts the character run of each number.
// Depends on sidc_pkg.
`default_nettype none

module sidc_text_checker #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic [sidc_pkg::NUMBER_W-1:0] number,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic [sidc_pkg::CHAR_W-1:0]   text_char,
    input  wire logic                          last_char,
    output int                                 errors,
    output int                                 pending
);
    import sidc_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              fin;
    } text_sym_t;

    localparam logic [NUMBER_W-1:0] WIDTH_MASK = {NUMBER_W{1'b1}} >> (NUMBER_W - VALUE_BITS);

    text_sym_t expected_text[$];

    // decimal rendering of the low VALUE_BITS bits, most significant first
    function automatic void render_decimal(logic [NUMBER_W-1:0] value);
        logic [NUMBER_W-1:0] raw;
        logic [NUMBER_W-1:0] mag;
        logic                minus;
        logic [3:0]          digits[20];
        int                  ndig;
        text_sym_t           sym;
        raw   = value & WIDTH_MASK;
        minus = raw[VALUE_BITS-1];
        mag   = minus ? ((~raw + 1'b1) & WIDTH_MASK) : raw;
        ndig  = 0;
        do
        begin
            digits[ndig] = 4'(mag % 10);
            mag = mag / 10;
            ndig++;
        end
        while (mag != 0 && ndig < 19);
        if (minus)
        begin
            sym.code = CH_MINUS;
            sym.fin  = 1'b0;
            expected_text.push_back(sym);
        end
        for (int d = ndig - 1; d >= 0; d--)
        begin
            sym.code = CH_ZERO + CHAR_W'(digits[d]);
            sym.fin  = (d == 0);
            expected_text.push_back(sym);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        text_sym_t want;
        int        bad;
        if (!rst_n)
        begin
            expected_text.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            bad = 0;
            if (in_valid && in_ready)
                render_decimal(number);
            if (out_valid && out_ready)
            begin
                if (expected_text.size() == 0)
                begin
                    $error("text_char: expected none, actual %0d", text_char);
                    bad++;
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (text_char !== want.code)
                    begin
                        $error("text_char: expected %0d, actual %0d", want.code, text_char);
                        bad++;
                    end
                    if (last_char !== want.fin)
                    begin
                        $error("last_char: expected %0d, actual %0d", want.fin, last_char);
                        bad++;
                    end
                end
            end
            errors  <= errors + bad;
            pending <= expected_text.size();
        end
    end

endmodule

`default_nettype wire

// ===== sim/signed_int_to_decimal_ascii_tb.sv =====
// Top of the decimal text converter testbench: clock, reset and number stimulus.
// Instantiates signed_int_to_decimal_ascii and sidc_text_checker; needs sidc_pkg.
`default_nettype none

module signed_int_to_decimal_ascii_tb;
    import sidc_pkg::*;

    localparam int RANDOM_ITEMS = 450;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [NUMBER_W-1:0] number;
    logic                out_valid;
    logic                out_ready;
    logic [CHAR_W-1:0]   text_char;
    logic                last_char;
    logic                steady;
    int                  errors;
    int                  pending;

    signed_int_to_decimal_ascii uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .number    (number),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .text_char (text_char),
        .last_char (last_char)
    );

    sidc_text_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .number    (number),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .text_char (text_char),
        .last_char (last_char),
        .errors    (errors),
        .pending   (pending)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= steady || ($urandom_range(99) >= 7);
    end

    function automatic logic [NUMBER_W-1:0] pow10(int k);
        logic [NUMBER_W-1:0] p;
        p = 1;
        for (int i = 0; i < k; i++)
            p = p * 10;
        return p;
    endfunction

    function automatic logic [NUMBER_W-1:0] pick_number();
        logic [NUMBER_W-1:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5:
            begin
                v = {$urandom, $urandom} >> $urandom_range(63);
                if ($urandom_range(1))
                    v = -v;
            end
            6, 7:
                v = {$urandom, $urandom};
            8:
            begin
                v = pow10($urandom_range(18)) - NUMBER_W'($urandom_range(1));
                if ($urandom_range(1))
                    v = -v;
            end
            default:
                case ($urandom_range(3))
                    0: v = {1'b1, {(NUMBER_W-1){1'b0}}};
                    1: v = {1'b0, {(NUMBER_W-1){1'b1}}};
                    2: v = '0;
                    default: v = '1;
                endcase
        endcase
        return v;
    endfunction

    task automatic send_number(logic [NUMBER_W-1:0] value);
        number   <= value;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        if (!steady && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            number   <= {$urandom, $urandom};
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [NUMBER_W-1:0] directed[$];
        rst_n    = 1'b0;
        in_valid = 1'b0;
        number   = '0;
        steady   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{
            64'd0, 64'd1, -64'sd1, 64'd9, -64'sd9, 64'd10, 64'd99, 64'd100, -64'sd100,
            64'd12345, pow10(18) - 1, pow10(18), -pow10(18), pow10(19) / 2,
            {1'b0, {63{1'b1}}}, {1'b0, {62{1'b1}}, 1'b0},
            {1'b1, {63{1'b0}}}, {1'b1, {62{1'b0}}, 1'b1},
            64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
            64'h0000_0001_0000_0000, -64'sh0000_0001_0000_0000
        };
        foreach (directed[i])
            send_number(directed[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady <= (n >= 150 && n < 250);
            send_number(pick_number());
        end
        in_valid <= 1'b0;
        steady   <= 1'b0;
        @(posedge clk);

        wait (pending == 0);
        repeat (100) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("signed_int_to_decimal_ascii regression: pass");
        else
            $display("signed_int_to_decimal_ascii regression: fail");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("signed_int_to_decimal_ascii regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== signed_int_to_decimal_ascii.f =====
+incdir+src
src/sidc_pkg.sv
src/sidc_dp.sv
src/sidc_ctrl.sv
src/signed_int_to_decimal_ascii.sv
sim/sidc_text_checker.sv
sim/signed_int_to_decimal_ascii_tb.sv
